// File: hw/rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// Great-circle distance shared definitions
// Widths, fixed-point constants, arctangent table and Q1.30 helpers.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int CORDIC_STEPS    = 24;
    localparam int ANGLE_FRAC_BITS = 22;

    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int RAD_W  = 23;
    localparam int DIST_W = 29;

    localparam int BAM_W  = 32;        // binary angle, full turn = 2^32
    localparam int DIFF_W = 32;        // signed angle before scaling
    localparam int CW     = 34;        // CORDIC datapath
    localparam int Q_W    = 32;        // signed Q1.30
    localparam int A_W    = 31;        // unsigned 0 .. 1.0 in Q1.30
    localparam int ROOT_W = 64;
    localparam int ROOT_STEPS = 32;
    localparam int U_W    = RAD_W + 32;

    // degrees to binary angle: divide by 45 after a power-of-two pre-scale
    localparam int PRE_W    = 32 - ANGLE_FRAC_BITS;
    localparam int SH_FULL  = PRE_W - 3;
    localparam int SH_HALF  = PRE_W - 4;
    localparam int RND      = 22;
    localparam int DIVISOR  = 45;
    localparam int K_SHIFT  = 37;
    localparam int K_W      = 64 - K_SHIFT;
    localparam logic [31:0] K_RCP = 32'((64'd1 << K_SHIFT) / DIVISOR);
    localparam int R_W      = 7;
    localparam int TW       = SH_FULL + 6;
    localparam int T_SHIFT  = TW + 6;
    localparam logic [31:0] T_RCP =
        32'(((64'd1 << T_SHIFT) + DIVISOR - 1) / DIVISOR);

    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6378137;
    localparam logic [31:0]      PI_Q30       = 32'd3373259426;

    typedef logic signed [CW-1:0]  t_cordic;
    typedef logic signed [Q_W-1:0] t_q30;
    typedef logic [BAM_W-1:0]      t_bam;
    typedef logic [A_W-1:0]        t_unit;
    typedef logic [ROOT_W-1:0]     t_root;

    typedef struct packed {
        logic en;
        logic vld;
    } t_ctl;

    localparam t_cordic ONE_Q30  = t_cordic'(64'd1073741824);
    localparam t_cordic HALF_TURN = t_cordic'(64'd2147483648);
    localparam t_cordic GAIN_Q30 = t_cordic'(64'd652032874);

    function automatic t_cordic atan_bam(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 536870912;   1: v = 316933406;   2: v = 167458907;
            3: v = 85004756;    4: v = 42667331;    5: v = 21354465;
            6: v = 10679838;    7: v = 5340245;     8: v = 2670163;
            9: v = 1335087;     10: v = 667544;     11: v = 333772;
            12: v = 166886;     13: v = 83443;      14: v = 41722;
            15: v = 20861;      16: v = 10430;      17: v = 5215;
            18: v = 2608;       19: v = 1304;       20: v = 652;
            21: v = 326;        22: v = 163;        23: v = 81;
            24: v = 41;         25: v = 20;         26: v = 10;
            27: v = 5;          28: v = 3;          29: v = 1;
            30: v = 1;
            default: v = 0;
        endcase
        return t_cordic'({1'b0, v});
    endfunction

    function automatic t_q30 clamp_q30(input t_cordic v);
        t_cordic r;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end else begin
            r = v;
        end
        return t_q30'(r);
    endfunction

    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b) + (64'sd1 <<< 29);
        return t_q30'(p >>> 30);
    endfunction

endpackage

// File: hw/rtl/gcd_bam.sv
// ----------------------------------------------------------------------------
// Degrees to binary angle
// Rounds a signed angle in fixed-point degrees to a 32-bit binary angle,
// with a constant reciprocal divide by 45 over five stages.
// ----------------------------------------------------------------------------
module gcd_bam (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gcd_pkg::t_ctl        i_ctl,
    input  logic                 i_half,
    input  logic signed [31:0]   i_value,
    output logic                 o_vld,
    output gcd_pkg::t_bam        o_bam
);
    import gcd_pkg::*;

    logic [4:0]        r_vld;
    logic [3:0]        r_neg;
    logic [31:0]       r_mag1, r_mag2;
    logic [63:0]       r_prod;
    logic [K_W-1:0]    r_k3, r_k4;
    logic [R_W-1:0]    r_r3;
    logic [TW-1:0]     r_w4;
    t_bam              r_q;
    logic [K_W-1:0]    n_k;
    logic [R_W-1:0]    n_r;
    logic [63:0]       n_t;
    t_bam              n_q;

    function automatic logic [31:0] r_k3_mul(input logic [K_W-1:0] k);
        return 32'(k) * 32'(DIVISOR);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[3:0], i_ctl.vld};
        end
    end

    always_comb begin
        n_k = r_prod[63:K_SHIFT];
        n_r = R_W'(r_mag2 - 32'(r_k3_mul(n_k)));
        n_t = (64'(r_w4) * 64'(T_RCP)) >> T_SHIFT;
        n_q = (t_bam'(r_k4) << (i_half ? SH_HALF : SH_FULL)) + t_bam'(n_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_neg  <= {r_neg[2:0], i_value[31]};
            r_mag1 <= i_value[31] ? 32'(-i_value) : 32'(i_value);
            r_prod <= 64'(r_mag1) * 64'(K_RCP);
            r_mag2 <= r_mag1;
            r_k3   <= n_k;
            r_r3   <= n_r;
            // reciprocal may fall one short: fix once
            if (r_r3 >= R_W'(DIVISOR)) begin
                r_k4 <= r_k3 + 1'b1;
                r_w4 <= (TW'(r_r3 - R_W'(DIVISOR)) << (i_half ? SH_HALF : SH_FULL))
                        + TW'(RND);
            end else begin
                r_k4 <= r_k3;
                r_w4 <= (TW'(r_r3) << (i_half ? SH_HALF : SH_FULL)) + TW'(RND);
            end
            r_q    <= r_neg[3] ? -n_q : n_q;
        end
    end

    assign o_vld = r_vld[4];
    assign o_bam = r_q;

endmodule

// File: hw/rtl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Sine and cosine of a binary angle, one iteration per stage, Q1.30 out.
// ----------------------------------------------------------------------------
module gcd_sincos (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gcd_pkg::t_ctl  i_ctl,
    input  gcd_pkg::t_bam  i_bam,
    output logic           o_vld,
    output gcd_pkg::t_q30  o_sin,
    output gcd_pkg::t_q30  o_cos
);
    import gcd_pkg::*;

    logic [CORDIC_STEPS+1:0] r_vld;
    t_cordic                 r_x [CORDIC_STEPS+1];
    t_cordic                 r_y [CORDIC_STEPS+1];
    t_cordic                 r_z [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]   r_flip;
    t_q30                    r_sin, r_cos;
    t_cordic                 n_z;
    logic                    n_flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[CORDIC_STEPS:0], i_ctl.vld};
        end
    end

    // fold the angle into the right half plane
    always_comb begin
        n_z    = t_cordic'($signed(i_bam));
        n_flip = 1'b0;
        if (n_z > ONE_Q30) begin
            n_z    = n_z - HALF_TURN;
            n_flip = 1'b1;
        end else if (n_z < -ONE_Q30) begin
            n_z    = n_z + HALF_TURN;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0]    <= GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= n_z;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_flip[g+1] <= r_flip[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_bam(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_bam(g);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_sin <= clamp_q30(r_flip[CORDIC_STEPS] ? -r_y[CORDIC_STEPS]
                                                    : r_y[CORDIC_STEPS]);
            r_cos <= clamp_q30(r_flip[CORDIC_STEPS] ? -r_x[CORDIC_STEPS]
                                                    : r_x[CORDIC_STEPS]);
        end
    end

    assign o_vld = r_vld[CORDIC_STEPS+1];
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// File: hw/rtl/gcd_root.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// floor(sqrt(x * 2^30)) by digit-by-digit restoring steps, one per stage.
// ----------------------------------------------------------------------------
module gcd_root (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gcd_pkg::t_ctl  i_ctl,
    input  gcd_pkg::t_unit i_value,
    output logic           o_vld,
    output gcd_pkg::t_unit o_root
);
    import gcd_pkg::*;

    logic [ROOT_STEPS:0] r_vld;
    t_root               r_n   [ROOT_STEPS+1];
    t_root               r_res [ROOT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[ROOT_STEPS-1:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_n[0]   <= t_root'(i_value) << 30;
            r_res[0] <= '0;
        end
    end

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
        localparam t_root STEP_BIT = t_root'(1) << (2*ROOT_STEPS - 2 - 2*g);
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (r_n[g] >= r_res[g] + STEP_BIT) begin
                    r_n[g+1]   <= r_n[g] - (r_res[g] + STEP_BIT);
                    r_res[g+1] <= (r_res[g] >> 1) + STEP_BIT;
                end else begin
                    r_n[g+1]   <= r_n[g];
                    r_res[g+1] <= r_res[g] >> 1;
                end
            end
        end
    end

    assign o_vld  = r_vld[ROOT_STEPS];
    assign o_root = r_res[ROOT_STEPS][A_W-1:0];

endmodule

// File: hw/rtl/gcd_atan.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// atan2(y, x) as a binary angle, one iteration per stage, clamped to 0..90.
// ----------------------------------------------------------------------------
module gcd_atan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gcd_pkg::t_ctl  i_ctl,
    input  gcd_pkg::t_unit i_y,
    input  gcd_pkg::t_unit i_x,
    output logic           o_vld,
    output gcd_pkg::t_unit o_angle
);
    import gcd_pkg::*;

    logic [CORDIC_STEPS+1:0] r_vld;
    t_cordic                 r_x [CORDIC_STEPS+1];
    t_cordic                 r_y [CORDIC_STEPS+1];
    t_cordic                 r_z [CORDIC_STEPS+1];
    t_unit                   r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[CORDIC_STEPS:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0] <= t_cordic'({1'b0, i_x});
            r_y[0] <= t_cordic'({1'b0, i_y});
            r_z[0] <= '0;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_bam(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_bam(g);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (r_z[CORDIC_STEPS] < 0) begin
                r_angle <= '0;
            end else if (r_z[CORDIC_STEPS] > ONE_Q30) begin
                r_angle <= A_W'(ONE_Q30);
            end else begin
                r_angle <= A_W'(r_z[CORDIC_STEPS]);
            end
        end
    end

    assign o_vld   = r_vld[CORDIC_STEPS+1];
    assign o_angle = r_angle;

endmodule

// File: hw/rtl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// Great-circle distance
// Haversine distance between two latitude/longitude points, fixed point.
// ----------------------------------------------------------------------------
// One point pair enters per clock while o_stall is low, and the rate is set
// by the fully pipelined CORDIC and root stages, each doing one iteration
// per register. While a finished result is held by i_stall the whole
// pipeline holds with it and o_stall is raised. The radius register is
// sampled through a multiply register, so write it only while no pair is
// in flight.
module great_circle_distance (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [gcd_pkg::LAT_W-1:0]  i_first_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]  i_first_longitude,
    input  logic signed [gcd_pkg::LAT_W-1:0]  i_second_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]  i_second_longitude,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gcd_pkg::DIST_W-1:0]        o_distance_sixteenths,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gcd_pkg::RAD_W-1:0]         i_cfg_data
);
    import gcd_pkg::*;

    logic               w_en;
    logic [RAD_W-1:0]   r_radius;
    logic [U_W-1:0]     r_u;

    logic               r_s0_vld;
    logic signed [31:0] r_lat1, r_lat2, r_dphi, r_dlam;

    logic               w_bam_vld;
    t_bam               w_bam_lat1, w_bam_lat2, w_bam_dphi, w_bam_dlam;
    logic               w_sc_vld;
    t_q30               w_c1, w_c2, w_sdp, w_sdl;

    logic [2:0]         r_m_vld;
    t_q30               r_sdp2, r_cc, r_sdl2, r_sdp2_b, r_prod;
    t_unit              r_a, r_b;
    t_q30               n_sum;

    logic               w_rt_vld;
    t_unit              w_root_a, w_root_b;
    logic               w_at_vld;
    t_unit              w_angle;

    logic               r_f_vld;
    logic [63:0]        r_plo, r_phi;
    logic               r_out_vld;
    logic [DIST_W-1:0]  r_out;
    logic [63:0]        n_lo, n_sum_d;

    assign w_en        = !(r_out_vld && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radius <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= U_W'(r_radius) * U_W'(PI_Q30);
    end

    // input beat: widen and take the differences, halved later in gcd_bam
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat1 <= 32'(i_first_latitude);
            r_lat2 <= 32'(i_second_latitude);
            r_dphi <= 32'(i_second_latitude) - 32'(i_first_latitude);
            r_dlam <= 32'(i_second_longitude) - 32'(i_first_longitude);
        end
    end

    gcd_bam u_bam_lat1 (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: r_s0_vld}), .i_half(1'b0),
        .i_value(r_lat1), .o_vld(w_bam_vld), .o_bam(w_bam_lat1)
    );
    gcd_bam u_bam_lat2 (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: r_s0_vld}), .i_half(1'b0),
        .i_value(r_lat2), .o_vld(), .o_bam(w_bam_lat2)
    );
    gcd_bam u_bam_dphi (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: r_s0_vld}), .i_half(1'b1),
        .i_value(r_dphi), .o_vld(), .o_bam(w_bam_dphi)
    );
    gcd_bam u_bam_dlam (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: r_s0_vld}), .i_half(1'b1),
        .i_value(r_dlam), .o_vld(), .o_bam(w_bam_dlam)
    );

    gcd_sincos u_sc_lat1 (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: w_bam_vld}), .i_bam(w_bam_lat1),
        .o_vld(w_sc_vld), .o_sin(), .o_cos(w_c1)
    );
    gcd_sincos u_sc_lat2 (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: w_bam_vld}), .i_bam(w_bam_lat2),
        .o_vld(), .o_sin(), .o_cos(w_c2)
    );
    gcd_sincos u_sc_dphi (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: w_bam_vld}), .i_bam(w_bam_dphi),
        .o_vld(), .o_sin(w_sdp), .o_cos()
    );
    gcd_sincos u_sc_dlam (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: w_bam_vld}), .i_bam(w_bam_dlam),
        .o_vld(), .o_sin(w_sdl), .o_cos()
    );

    // haversine term over three product stages
    assign n_sum = r_sdp2_b + r_prod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sdp2   <= mul_q30(w_sdp, w_sdp);
            r_cc     <= mul_q30(w_c1, w_c2);
            r_sdl2   <= mul_q30(w_sdl, w_sdl);
            r_sdp2_b <= r_sdp2;
            r_prod   <= mul_q30(r_cc, r_sdl2);
            if (n_sum < 0) begin
                r_a <= '0;
                r_b <= A_W'(ONE_Q30);
            end else if (n_sum > t_q30'(ONE_Q30)) begin
                r_a <= A_W'(ONE_Q30);
                r_b <= '0;
            end else begin
                r_a <= A_W'(n_sum);
                r_b <= A_W'(ONE_Q30) - A_W'(n_sum);
            end
        end
    end

    gcd_root u_root_a (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: r_m_vld[2]}), .i_value(r_a),
        .o_vld(w_rt_vld), .o_root(w_root_a)
    );
    gcd_root u_root_b (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: r_m_vld[2]}), .i_value(r_b),
        .o_vld(), .o_root(w_root_b)
    );

    gcd_atan u_atan (
        .i_clk, .i_rst_n, .i_ctl('{en: w_en, vld: w_rt_vld}), .i_y(w_root_a),
        .i_x(w_root_b), .o_vld(w_at_vld), .o_angle(w_angle)
    );

    // R * pi * c, split to keep each multiply within 32 bits
    always_comb begin
        n_lo    = r_plo + (64'd1 << 55);
        n_sum_d = r_phi + (n_lo >> 32);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_plo <= 64'(r_u[31:0]) * 64'(w_angle);
            r_phi <= 64'(r_u[U_W-1:32]) * 64'(w_angle);
            r_out <= n_sum_d[24 +: DIST_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_m_vld   <= '0;
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld  <= i_valid;
            r_m_vld   <= {r_m_vld[1:0], w_sc_vld};
            r_f_vld   <= w_at_vld;
            r_out_vld <= r_f_vld;
        end
    end

    assign o_valid               = r_out_vld;
    assign o_distance_sixteenths = r_out;

endmodule

// File: hw/rtl/gcd_checker.sv
// ----------------------------------------------------------------------------
// Great-circle distance port checker
// Watches the top-level ports for handshake and stall behaviour.
// ----------------------------------------------------------------------------
module gcd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic signed [gcd_pkg::LAT_W-1:0]  i_first_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]  i_first_longitude,
    input  logic signed [gcd_pkg::LAT_W-1:0]  i_second_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]  i_second_longitude,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [gcd_pkg::DIST_W-1:0]        o_distance_sixteenths,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [gcd_pkg::RAD_W-1:0]         i_cfg_data
);
    // only a held result may back-pressure the input
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without a held result");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_distance_sixteenths))
        else $error("result changed under stall");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
